[sv/stlex_pkg.sv]
// stlex_pkg: shared types and constants of the settings text lexer
// token kinds, the token record and the per-byte token pair that the queue carries
// no dependencies
package stlex_pkg;

    // token kind codes
    localparam logic [3:0] K_OPEN    = 4'd0;
    localparam logic [3:0] K_CLOSE   = 4'd1;
    localparam logic [3:0] K_COMMA   = 4'd2;
    localparam logic [3:0] K_EQUALS  = 4'd3;
    localparam logic [3:0] K_SEMI    = 4'd4;
    localparam logic [3:0] K_TRUE    = 4'd5;
    localparam logic [3:0] K_FALSE   = 4'd6;
    localparam logic [3:0] K_STRING  = 4'd7;
    localparam logic [3:0] K_INT     = 4'd8;
    localparam logic [3:0] K_FLOAT   = 4'd9;
    localparam logic [3:0] K_NAME    = 4'd10;
    localparam logic [3:0] K_INVALID = 4'd11;

    // keyword lengths
    localparam logic [15:0] LEN_TRUE  = 16'd4;
    localparam logic [15:0] LEN_FALSE = 16'd5;

    // entries of the queue between front and back
    localparam int unsigned QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [3:0]  kind;
        logic [15:0] start;
        logic [15:0] length;
    } t_token;

    // all tokens caused by one byte: first, and second when two is set
    typedef struct packed {
        logic   two;
        t_token tok0;
        t_token tok1;
    } t_pair;

endpackage

[sv/stlex_front.sv]
// stlex_front: lexer state machine, classifies each accepted byte
// produces the zero, one or two tokens of the byte as one queue request
// depends on stlex_pkg
module stlex_front #(
    parameter longint unsigned OFFSET_SPAN = 65536
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_text_byte,
    output logic             o_wr,
    output stlex_pkg::t_pair o_pair
);
    import stlex_pkg::*;

    localparam int PW = $clog2(OFFSET_SPAN);

    localparam logic [7:0] CH_OPEN   = "{";
    localparam logic [7:0] CH_CLOSE  = "}";
    localparam logic [7:0] CH_COMMA  = ",";
    localparam logic [7:0] CH_EQUALS = "=";
    localparam logic [7:0] CH_SEMI   = ";";
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_MINUS  = "-";
    localparam logic [7:0] CH_PLUS   = "+";
    localparam logic [7:0] CH_ZERO   = "0";
    localparam logic [7:0] CH_DOT    = ".";
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_LF     = 8'h0a;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    typedef enum logic [3:0] {
        M_IDLE, M_BSLASH, M_COMMENT, M_STRING, M_WORD, M_SIGN,
        M_INT, M_ZERO, M_FRAC, M_EXPSIGN, M_EXP
    } t_mode;

    typedef struct packed {
        t_mode         mode;
        logic [PW-1:0] start;
        logic [2:0]    kwp;
        logic          kwc;
        logic          emit;
        t_token        tok;
    } t_fresh;

    t_mode         r_mode, n_mode;
    logic [PW-1:0] r_start, n_start;
    logic [PW-1:0] r_pos, pos_next;
    logic [2:0]    r_kwp, n_kwp;
    logic          r_kwc, n_kwc;
    logic          r_esc, n_esc;

    logic [7:0]    c;
    logic          do_fresh;
    logic [7:0]    fresh_c;
    t_fresh        fr;
    logic          a_v;
    t_token        a_tok;
    logic [7:0]    want;
    logic [2:0]    klen;
    logic          kw_hit;
    logic [15:0]   cur_len;

    function automatic logic f_digit(input logic [7:0] ch);
        f_digit = (ch >= "0") && (ch <= "9");
    endfunction

    function automatic logic f_letter(input logic [7:0] ch);
        f_letter = ((ch >= "a") && (ch <= "z")) || ((ch >= "A") && (ch <= "Z"));
    endfunction

    function automatic logic f_exp(input logic [7:0] ch);
        f_exp = (ch == "e") || (ch == "E");
    endfunction

    function automatic t_token f_tok(input logic [3:0] kind, input logic [PW-1:0] start,
                                     input logic [15:0] length);
        t_token t;
        t.kind   = kind;
        t.start  = 16'(start);
        t.length = length;
        f_tok = t;
    endfunction

    // lex a byte from the idle state
    function automatic t_fresh f_fresh(input logic [7:0] ch, input logic [PW-1:0] pos,
                                       input logic [PW-1:0] pos_inc);
        t_fresh f;
        f.mode  = M_IDLE;
        f.start = pos;
        f.kwp   = 3'd0;
        f.kwc   = 1'b0;
        f.emit  = 1'b0;
        f.tok   = f_tok(K_INVALID, pos, 16'd0);
        if (!(ch inside {CH_SPACE, 8'h09, CH_LF, 8'h0d})) begin
            case (ch)
                CH_OPEN: begin
                    f.emit = 1'b1; f.tok = f_tok(K_OPEN, pos, 16'd1);
                end
                CH_CLOSE: begin
                    f.emit = 1'b1; f.tok = f_tok(K_CLOSE, pos, 16'd1);
                end
                CH_COMMA: begin
                    f.emit = 1'b1; f.tok = f_tok(K_COMMA, pos, 16'd1);
                end
                CH_EQUALS: begin
                    f.emit = 1'b1; f.tok = f_tok(K_EQUALS, pos, 16'd1);
                end
                CH_SEMI: begin
                    f.emit = 1'b1; f.tok = f_tok(K_SEMI, pos, 16'd1);
                end
                CH_QUOTE: begin
                    f.mode = M_STRING; f.start = pos_inc;
                end
                CH_BSLASH: f.mode = M_BSLASH;
                CH_MINUS:  f.mode = M_SIGN;
                CH_ZERO:   f.mode = M_ZERO;
                default: begin
                    if (f_digit(ch)) begin
                        f.mode = M_INT;
                    end else if (f_letter(ch)) begin
                        f.mode = M_WORD;
                        if (ch == "t") begin
                            f.kwp = 3'd1;
                        end else if (ch == "f") begin
                            f.kwp = 3'd1; f.kwc = 1'b1;
                        end
                    end else begin
                        f.emit = 1'b1;
                    end
                end
            endcase
        end
        f_fresh = f;
    endfunction

    assign c = i_text_byte;

    // wrapping byte offset
    assign pos_next = (r_pos == PW'(OFFSET_SPAN - 1)) ? '0 : r_pos + 1'b1;

    // length from the token start to the current byte, modulo the span
    always_comb begin
        logic [PW:0] d;
        d = {1'b0, r_pos} - {1'b0, r_start};
        if (r_pos < r_start) begin
            d = d + (PW+1)'(OFFSET_SPAN);
        end
        cur_len = 16'(d[PW-1:0]);
    end

    // expected next keyword letter
    always_comb begin
        klen = r_kwc ? 3'd5 : 3'd4;
        case (r_kwp)
            3'd1:    want = r_kwc ? "a" : "r";
            3'd2:    want = r_kwc ? "l" : "u";
            3'd3:    want = r_kwc ? "s" : "e";
            3'd4:    want = r_kwc ? "e" : 8'h00;
            default: want = 8'h00;
        endcase
        kw_hit = (r_kwp != 3'd0) && (r_kwp < klen) && (c == want);
    end

    // next state and the token ended by this byte
    always_comb begin
        n_mode   = r_mode;
        n_start  = r_start;
        n_kwp    = r_kwp;
        n_kwc    = r_kwc;
        n_esc    = r_esc;
        do_fresh = 1'b0;
        fresh_c  = c;
        a_v      = 1'b0;
        a_tok    = f_tok(K_INVALID, r_pos, 16'd0);
        case (r_mode)
            M_BSLASH: begin
                if (c == CH_BSLASH) begin
                    n_mode = M_COMMENT;
                end else begin
                    a_v = 1'b1; a_tok = f_tok(K_INVALID, r_start, 16'd0); do_fresh = 1'b1;
                end
            end
            M_COMMENT: begin
                if (c == CH_LF) begin
                    n_mode = M_IDLE;
                end else if (c == CH_NUL) begin
                    a_v = 1'b1; n_mode = M_IDLE;
                end
            end
            M_STRING: begin
                if (c == CH_NUL) begin
                    a_v = 1'b1; do_fresh = 1'b1; fresh_c = CH_SPACE;
                end else if (r_esc) begin
                    n_esc = 1'b0;
                end else if (c == CH_BSLASH) begin
                    n_esc = 1'b1;
                end else if (c == CH_QUOTE) begin
                    a_v = 1'b1; a_tok = f_tok(K_STRING, r_start, cur_len);
                    do_fresh = 1'b1; fresh_c = CH_SPACE;
                end
            end
            M_WORD: begin
                if (kw_hit) begin
                    n_kwp = r_kwp + 3'd1;
                    if (r_kwp + 3'd1 == klen) begin
                        a_v   = 1'b1;
                        a_tok = r_kwc ? f_tok(K_FALSE, r_start, LEN_FALSE)
                                      : f_tok(K_TRUE, r_start, LEN_TRUE);
                        n_mode = M_IDLE; n_kwp = 3'd0; n_kwc = 1'b0;
                    end
                end else begin
                    n_kwp = 3'd0;
                    if (!(f_letter(c) || f_digit(c))) begin
                        a_v = 1'b1; a_tok = f_tok(K_NAME, r_start, cur_len); do_fresh = 1'b1;
                    end
                end
            end
            M_SIGN, M_INT, M_ZERO: begin
                if (r_mode == M_SIGN && c == CH_ZERO) begin
                    n_mode = M_ZERO;
                end else if (r_mode != M_ZERO && f_digit(c)) begin
                    n_mode = M_INT;
                end else if (c == CH_DOT) begin
                    n_kwc = 1'b1; n_mode = M_FRAC;
                end else if (f_exp(c)) begin
                    n_mode = M_EXPSIGN;
                end else begin
                    a_v = 1'b1; a_tok = f_tok(r_kwc ? K_FLOAT : K_INT, r_start, cur_len);
                    do_fresh = 1'b1;
                end
            end
            M_FRAC: begin
                if (f_exp(c)) begin
                    n_mode = M_EXPSIGN;
                end else if (!f_digit(c)) begin
                    a_v = 1'b1; a_tok = f_tok(r_kwc ? K_FLOAT : K_INT, r_start, cur_len);
                    do_fresh = 1'b1;
                end
            end
            M_EXPSIGN: begin
                if (c == CH_PLUS || c == CH_MINUS || f_digit(c)) begin
                    n_mode = M_EXP;
                end else begin
                    a_v = 1'b1; a_tok = f_tok(r_kwc ? K_FLOAT : K_INT, r_start, cur_len);
                    do_fresh = 1'b1;
                end
            end
            M_EXP: begin
                if (!f_digit(c)) begin
                    a_v = 1'b1; a_tok = f_tok(r_kwc ? K_FLOAT : K_INT, r_start, cur_len);
                    do_fresh = 1'b1;
                end
            end
            default: do_fresh = 1'b1;
        endcase

        fr = f_fresh(fresh_c, r_pos, pos_next);
        if (do_fresh) begin
            n_mode  = fr.mode;
            n_start = fr.start;
            n_kwp   = fr.kwp;
            n_kwc   = fr.kwc;
            n_esc   = 1'b0;
        end
    end

    // pack the byte's tokens into one queue request
    always_comb begin
        o_pair.two  = a_v && do_fresh && fr.emit;
        o_pair.tok0 = a_v ? a_tok : fr.tok;
        o_pair.tok1 = fr.tok;
        o_wr        = i_accept && (a_v || (do_fresh && fr.emit));
    end

    // lexer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_start <= '0;
            r_pos   <= '0;
            r_kwp   <= 3'd0;
            r_kwc   <= 1'b0;
            r_esc   <= 1'b0;
        end else if (i_accept) begin
            r_mode  <= n_mode;
            r_start <= n_start;
            r_pos   <= pos_next;
            r_kwp   <= n_kwp;
            r_kwc   <= n_kwc;
            r_esc   <= n_esc;
        end
    end

endmodule

[sv/stlex_queue.sv]
// stlex_queue: short register queue of token pairs between front and back
// one write and one read a cycle, full and empty from the registered count
// depends on stlex_pkg
module stlex_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  stlex_pkg::t_pair i_pair,
    input  logic             i_rd,
    output stlex_pkg::t_pair o_head,
    output logic             o_full,
    output logic             o_empty
);
    import stlex_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);

    t_pair         r_mem [QUEUE_DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic          do_wr, do_rd;

    assign o_full  = (r_cnt == (AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && !o_empty;
    assign o_head  = r_mem[r_rp];

    // storage
    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wp] <= i_pair;
        end
    end

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_wr) begin
                r_wp <= (r_wp == AW'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_rd) begin
                r_rp <= (r_rp == AW'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(do_wr) - (AW+1)'(do_rd);
        end
    end

endmodule

[sv/stlex_back.sv]
// stlex_back: splits queued token pairs into single result requests
// output register plus a holding slot for the second token of a pair
// depends on stlex_pkg
module stlex_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_empty,
    input  stlex_pkg::t_pair i_q_head,
    output logic             o_q_rd,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [3:0]       o_token_kind,
    output logic [15:0]      o_token_start,
    output logic [15:0]      o_token_length,
    output logic             o_last_of_run
);
    import stlex_pkg::*;

    logic   r_out_v;
    t_token r_out;
    logic   r_out_last;
    logic   r_sec_v;
    t_token r_sec;
    logic   load;

    // output register is free this cycle
    assign load   = !r_out_v || i_pop;
    assign o_q_rd = load && !r_sec_v && !i_q_empty;

    assign o_empty        = !r_out_v;
    assign o_token_kind   = r_out.kind;
    assign o_token_start  = r_out.start;
    assign o_token_length = r_out.length;
    assign o_last_of_run  = r_out_last;

    // result register and second-token slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
            r_sec_v <= 1'b0;
        end else if (load) begin
            if (r_sec_v) begin
                r_out_v    <= 1'b1;
                r_out      <= r_sec;
                r_out_last <= 1'b1;
                r_sec_v    <= 1'b0;
            end else if (!i_q_empty) begin
                r_out_v    <= 1'b1;
                r_out      <= i_q_head.tok0;
                r_out_last <= !i_q_head.two;
                r_sec      <= i_q_head.tok1;
                r_sec_v    <= i_q_head.two;
            end else begin
                r_out_v <= 1'b0;
            end
        end
    end

endmodule

[sv/settings_text_lexer.sv]
// settings_text_lexer: top level of the byte-serial settings text lexer
// front state machine, token pair queue and result back end
// depends on stlex_pkg, stlex_front, stlex_queue, stlex_back

// The lexer takes one text byte per cycle on a push/full queue port and
// returns tokens (kind, start offset, length, last_of_run) on an empty/pop
// queue port. The front state machine classifies each accepted byte in the
// cycle it is pushed and writes all tokens caused by that byte (none, one or
// two) as one entry into a four-entry queue; the back end hands out one token
// per cycle while results are popped, and a token passes from the queue
// through the back end's output register to the result ports. Bytes are taken
// every cycle while the queue has room; a run of bytes that each give two
// tokens, or results left unpopped, fill the queue and hold the input back.
// Offsets count modulo OFFSET_SPAN and are reported in 16 bits.
module settings_text_lexer #(
    parameter longint unsigned OFFSET_SPAN = 65536
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_text_byte,
    output logic        empty,
    input  logic        pop,
    output logic [3:0]  o_token_kind,
    output logic [15:0] o_token_start,
    output logic [15:0] o_token_length,
    output logic        o_last_of_run
);
    import stlex_pkg::*;

    logic  accept;
    logic  wr;
    t_pair pair;
    t_pair head;
    logic  q_empty;
    logic  q_rd;

    assign accept = push && !full;

    // byte classification
    stlex_front #(
        .OFFSET_SPAN(OFFSET_SPAN)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_text_byte (i_text_byte),
        .o_wr        (wr),
        .o_pair      (pair)
    );

    // decoupling queue
    stlex_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr),
        .i_pair  (pair),
        .i_rd    (q_rd),
        .o_head  (head),
        .o_full  (full),
        .o_empty (q_empty)
    );

    // result delivery
    stlex_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .i_q_head       (head),
        .o_q_rd         (q_rd),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_token_kind   (o_token_kind),
        .o_token_start  (o_token_start),
        .o_token_length (o_token_length),
        .o_last_of_run  (o_last_of_run)
    );

endmodule

[sv/stlex_checker.sv]
// stlex_checker: port-level checks of the settings text lexer, bound to the top
// depends on stlex_pkg and settings_text_lexer
module stlex_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        push,
    input logic        full,
    input logic [7:0]  i_text_byte,
    input logic        empty,
    input logic        pop,
    input logic [3:0]  o_token_kind,
    input logic [15:0] o_token_start,
    input logic [15:0] o_token_length,
    input logic        o_last_of_run
);
    import stlex_pkg::*;

    // reset leaves no result and room for input
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (empty && !full))
        else $error("results or full after reset");

    // a waiting result holds until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_token_kind) && $stable(o_token_start)
                              && $stable(o_token_length) && $stable(o_last_of_run)))
        else $error("waiting result changed");

    // invalid tokens have no length
    a_invalid_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_token_kind == K_INVALID) |-> (o_token_length == 16'd0))
        else $error("invalid token with length");

    // punctuation tokens are one byte
    a_punct_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_token_kind <= K_SEMI) |-> (o_token_length == 16'd1))
        else $error("punctuation token length");

    // keywords have their fixed length
    a_keyword_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_token_kind == K_TRUE || o_token_kind == K_FALSE)) |->
        ((o_token_kind == K_TRUE && o_token_length == LEN_TRUE) ||
         (o_token_kind == K_FALSE && o_token_length == LEN_FALSE)))
        else $error("keyword token length");

endmodule

bind settings_text_lexer stlex_checker u_stlex_checker (.*);
